@@ design/fpn3_pkg.sv @@
package fpn3_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DIV_STEPS = 19;

   // seed offset steps per axis, nearest Q0.16 of 0.191, 0.137 and 0.121
   localparam logic [13:0] OFF_X = 14'd12517;
   localparam logic [13:0] OFF_Y = 14'd8978;
   localparam logic [13:0] OFF_Z = 14'd7930;

   localparam logic [40:0] AMP_ONE = 41'd65536;
   localparam logic [42:0] AMP_CAP = 43'h100_0000_0000;

   typedef logic [3:0]         oct_idx_type;
   typedef logic [40:0]        amp_type;
   typedef logic signed [19:0] val_type;

   typedef enum logic [1:0] {
      CSR_SEED    = 2'd0,
      CSR_OCTAVES = 2'd1,
      CSR_PERSIST = 2'd2,
      CSR_BASEFRQ = 2'd3
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_ISSUE,
      ST_DRAIN,
      ST_DIVIDE,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic        load;
      logic        prep;
      logic        issue;
      oct_idx_type oct_idx;
      logic        div_init;
      logic        div_step;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic pipe_busy;
   } status_type;

   localparam logic [7:0] PERM [256] = '{
      8'd151, 8'd160, 8'd137, 8'd91, 8'd90, 8'd15, 8'd131, 8'd13,
      8'd201, 8'd95, 8'd96, 8'd53, 8'd194, 8'd233, 8'd7, 8'd225,
      8'd140, 8'd36, 8'd103, 8'd30, 8'd69, 8'd142, 8'd8, 8'd99,
      8'd37, 8'd240, 8'd21, 8'd10, 8'd23, 8'd190, 8'd6, 8'd148,
      8'd247, 8'd120, 8'd234, 8'd75, 8'd0, 8'd26, 8'd197, 8'd62,
      8'd94, 8'd252, 8'd219, 8'd203, 8'd117, 8'd35, 8'd11, 8'd32,
      8'd57, 8'd177, 8'd33, 8'd88, 8'd237, 8'd149, 8'd56, 8'd87,
      8'd174, 8'd20, 8'd125, 8'd136, 8'd171, 8'd168, 8'd68, 8'd175,
      8'd74, 8'd165, 8'd71, 8'd134, 8'd139, 8'd48, 8'd27, 8'd166,
      8'd77, 8'd146, 8'd158, 8'd231, 8'd83, 8'd111, 8'd229, 8'd122,
      8'd60, 8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92, 8'd41,
      8'd55, 8'd46, 8'd245, 8'd40, 8'd244, 8'd102, 8'd143, 8'd54,
      8'd65, 8'd25, 8'd63, 8'd161, 8'd1, 8'd216, 8'd80, 8'd73,
      8'd209, 8'd76, 8'd132, 8'd187, 8'd208, 8'd89, 8'd18, 8'd169,
      8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
      8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3, 8'd64,
      8'd52, 8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5, 8'd202,
      8'd38, 8'd147, 8'd118, 8'd126, 8'd255, 8'd82, 8'd85, 8'd212,
      8'd207, 8'd206, 8'd59, 8'd227, 8'd47, 8'd16, 8'd58, 8'd17,
      8'd182, 8'd189, 8'd28, 8'd42, 8'd223, 8'd183, 8'd170, 8'd213,
      8'd119, 8'd248, 8'd152, 8'd2, 8'd44, 8'd154, 8'd163, 8'd70,
      8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43, 8'd172, 8'd9,
      8'd129, 8'd22, 8'd39, 8'd253, 8'd19, 8'd98, 8'd108, 8'd110,
      8'd79, 8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
      8'd218, 8'd246, 8'd97, 8'd228, 8'd251, 8'd34, 8'd242, 8'd193,
      8'd238, 8'd210, 8'd144, 8'd12, 8'd191, 8'd179, 8'd162, 8'd241,
      8'd81, 8'd51, 8'd145, 8'd235, 8'd249, 8'd14, 8'd239, 8'd107,
      8'd49, 8'd192, 8'd214, 8'd31, 8'd181, 8'd199, 8'd106, 8'd157,
      8'd184, 8'd84, 8'd204, 8'd176, 8'd115, 8'd121, 8'd50, 8'd45,
      8'd127, 8'd4, 8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
      8'd222, 8'd114, 8'd67, 8'd29, 8'd24, 8'd72, 8'd243, 8'd141,
      8'd128, 8'd195, 8'd78, 8'd66, 8'd215, 8'd61, 8'd156, 8'd180
   };

endpackage

@@ design/fpn3_ctrl.sv @@
module fpn3_ctrl
   import fpn3_pkg::*;
#(
   parameter int MAX_OCTAVES = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [3:0] octave_count,
   output cmd_type    cmd,
   input  status_type status
);

   state_type   state_ff, state_in;
   oct_idx_type oct_cnt_ff, oct_cnt_in;
   logic [4:0]  div_cnt_ff, div_cnt_in;
   logic        out_valid_ff, out_valid_in;
   oct_idx_type n_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         oct_cnt_ff   <= '0;
         div_cnt_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         oct_cnt_ff   <= oct_cnt_in;
         div_cnt_ff   <= div_cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      if (octave_count == '0) begin
         n_eff = 4'd1;
      end else if (5'(octave_count) > 5'(MAX_OCTAVES)) begin
         n_eff = 4'(MAX_OCTAVES);
      end else begin
         n_eff = octave_count;
      end
   end

   always_comb begin
      state_in   = state_ff;
      oct_cnt_in = oct_cnt_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      cmd.oct_idx = oct_cnt_ff;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // no transfer while reset is held
            req_tready = ~reset;
            if (req_tvalid && !reset) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep   = 1'b1;
            oct_cnt_in = '0;
            state_in   = ST_ISSUE;
         end
         ST_ISSUE: begin
            cmd.issue = 1'b1;
            if (oct_cnt_ff == 4'(n_eff - 4'd1)) begin
               oct_cnt_in = '0;
               state_in   = ST_DRAIN;
            end else begin
               oct_cnt_in = 4'(oct_cnt_ff + 4'd1);
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               cmd.div_init = 1'b1;
               div_cnt_in   = '0;
               state_in     = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (div_cnt_ff == 5'(DIV_STEPS - 1)) begin
               state_in = ST_WRITE;
            end else begin
               div_cnt_in = 5'(div_cnt_ff + 5'd1);
            end
         end
         ST_WRITE: begin
            if (!out_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign out_valid_in = cmd.out_load | (out_valid_ff & ~rsp_tready);
   assign rsp_tvalid   = out_valid_ff;

endmodule

@@ design/fpn3_dpath.sv @@
module fpn3_dpath
   import fpn3_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic [95:0] in_data,
   input  logic [31:0] noise_seed,
   input  logic [17:0] persistence,
   input  logic [23:0] base_frequency,
   output logic [18:0] noise_value
);

   localparam int NSTG = 13;

   // input point and per-sample products
   logic signed [31:0] coord_ff [3];
   logic [39:0]        prod_ff [3];
   logic [23:0]        off_ff [3];
   amp_type            amp_ff;

   // pipeline control and amplitude carried alongside
   logic [NSTG:1] vld_ff;
   amp_type       ampp_ff [NSTG:1];

   logic [23:0] s1_ff [3];
   logic [7:0]  a2_ff, b2_ff, z2_ff;
   logic [15:0] f2_ff [3], f3_ff [3], f4_ff [3];
   logic [15:0] t2_2_ff [3], t3_3_ff [3], t3_4_ff [3], t4_4_ff [3];
   logic [15:0] t3_5_ff [3], t4_5_ff [3], t5_5_ff [3];
   logic [7:0]  hc3_ff [4];
   logic [3:0]  h4_ff [8];
   val_type     g5_ff [8], g6_ff [8];
   logic [16:0] fd6_ff [3];
   logic signed [37:0] px7_ff [4];
   val_type     ax7_ff [4];
   logic [16:0] fv7_ff, fw7_ff, fv8_ff, fw8_ff, fw9_ff, fw10_ff;
   val_type     bx8_ff [4];
   logic signed [37:0] py9_ff [2];
   val_type     ay9_ff [2];
   val_type     by10_ff [2];
   logic signed [37:0] pz11_ff;
   val_type     az11_ff;
   val_type     n12_ff;
   logic signed [41:0] mlo13_ff;
   logic signed [40:0] mhi13_ff;

   logic signed [63:0] total_ff;
   logic [43:0]        weight_ff;

   // divider
   logic [62:0] rem_ff, dvs_ff;
   logic [18:0] quo_ff;
   logic        neg_ff;
   logic [18:0] out_ff;

   function automatic val_type grad(input logic [3:0] h, input val_type x,
                                    input val_type y, input val_type z);
      val_type u, v, su, sv;
      u = (h < 4'd8) ? x : y;
      if (h < 4'd4) begin
         v = y;
      end else if (h == 4'd12 || h == 4'd14) begin
         v = x;
      end else begin
         v = z;
      end
      su = h[0] ? -u : u;
      sv = h[1] ? -v : v;
      return su + sv;
   endfunction

   function automatic val_type blend_sum(input val_type a, input logic signed [37:0] p);
      logic signed [37:0] r;
      r = (p + 38'sd32768) >>> FRAC_BITS;
      return a + r[19:0];
   endfunction

   function automatic logic [15:0] fmul(input logic [15:0] f, input logic [15:0] t);
      logic [32:0] m;
      m = 33'(f) * 33'(t) + 33'd32768;
      return m[31:16];
   endfunction

   function automatic logic signed [37:0] bmul(input logic [16:0] t, input val_type d);
      logic signed [17:0] ts;
      logic signed [37:0] p;
      ts = $signed({1'b0, t});
      p  = ts * d;
      return p;
   endfunction

   // combinational helpers
   logic [39:0]  sh [3];
   logic [58:0]  amp_prod;
   logic [42:0]  amp_rnd;
   val_type      cx [2], cy [2], cz [2];
   logic signed [22:0] fsum [3];
   logic [7:0]   xi2;
   logic signed [63:0] mag;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sh[k] = prod_ff[k] << cmd.oct_idx;
      end
      amp_prod = 59'(amp_ff) * 59'(persistence) + 59'd32768;
      amp_rnd  = amp_prod[58:16];
      xi2      = s1_ff[0][23:16];
      cx[0] = val_type'(f4_ff[0]);
      cy[0] = val_type'(f4_ff[1]);
      cz[0] = val_type'(f4_ff[2]);
      cx[1] = cx[0] - 20'sd65536;
      cy[1] = cy[0] - 20'sd65536;
      cz[1] = cz[0] - 20'sd65536;
      for (int k = 0; k < 3; k++) begin
         fsum[k] = 23'sd10 * $signed({7'd0, t3_5_ff[k]})
                 - 23'sd15 * $signed({7'd0, t4_5_ff[k]})
                 + 23'sd6 * $signed({7'd0, t5_5_ff[k]});
      end
      mag = total_ff[63] ? -total_ff : total_ff;
   end

   // sample set-up and accumulation
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         coord_ff[0] <= in_data[31:0];
         coord_ff[1] <= in_data[63:32];
         coord_ff[2] <= in_data[95:64];
      end
      if (cmd.prep) begin
         for (int k = 0; k < 3; k++) begin
            prod_ff[k] <= 40'(coord_ff[k] * $signed({1'b0, base_frequency}));
         end
         off_ff[0] <= 24'(28'(noise_seed[13:0]) * 28'(OFF_X));
         off_ff[1] <= 24'(28'(noise_seed[27:14]) * 28'(OFF_Y));
         off_ff[2] <= 24'(28'(noise_seed[31:28]) * 28'(OFF_Z));
         amp_ff    <= AMP_ONE;
         total_ff  <= '0;
         weight_ff <= '0;
      end else begin
         if (cmd.issue) begin
            amp_ff <= (amp_rnd > AMP_CAP) ? AMP_CAP[40:0] : amp_rnd[40:0];
         end
         if (vld_ff[NSTG]) begin
            total_ff  <= total_ff + 64'(mlo13_ff) + (64'(mhi13_ff) <<< 21);
            weight_ff <= weight_ff + 44'(ampp_ff[NSTG]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[NSTG-1:1], cmd.issue};
      end
   end

   // octave pipeline
   always_ff @(posedge clock) begin
      ampp_ff[1] <= amp_ff;
      for (int k = 2; k <= NSTG; k++) begin
         ampp_ff[k] <= ampp_ff[k-1];
      end
      // lattice position
      for (int k = 0; k < 3; k++) begin
         s1_ff[k] <= sh[k][39:16] + off_ff[k];
      end
      // first hash level, fade square
      a2_ff <= 8'(PERM[xi2] + s1_ff[1][23:16]);
      b2_ff <= 8'(PERM[8'(xi2 + 8'd1)] + s1_ff[1][23:16]);
      z2_ff <= s1_ff[2][23:16];
      for (int k = 0; k < 3; k++) begin
         f2_ff[k]   <= s1_ff[k][15:0];
         t2_2_ff[k] <= fmul(s1_ff[k][15:0], s1_ff[k][15:0]);
      end
      // second hash level
      hc3_ff[0] <= 8'(PERM[a2_ff] + z2_ff);
      hc3_ff[1] <= 8'(PERM[b2_ff] + z2_ff);
      hc3_ff[2] <= 8'(PERM[8'(a2_ff + 8'd1)] + z2_ff);
      hc3_ff[3] <= 8'(PERM[8'(b2_ff + 8'd1)] + z2_ff);
      for (int k = 0; k < 3; k++) begin
         f3_ff[k]   <= f2_ff[k];
         t3_3_ff[k] <= fmul(f2_ff[k], t2_2_ff[k]);
      end
      // corner hashes: near face then far face
      for (int k = 0; k < 4; k++) begin
         h4_ff[k]   <= PERM[hc3_ff[k]][3:0];
         h4_ff[k+4] <= PERM[8'(hc3_ff[k] + 8'd1)][3:0];
      end
      for (int k = 0; k < 3; k++) begin
         f4_ff[k]   <= f3_ff[k];
         t3_4_ff[k] <= t3_3_ff[k];
         t4_4_ff[k] <= fmul(f3_ff[k], t3_3_ff[k]);
      end
      // gradients, last fade power
      for (int k = 0; k < 8; k++) begin
         g5_ff[k] <= grad(h4_ff[k], cx[k % 2], cy[(k / 2) % 2], cz[k / 4]);
      end
      for (int k = 0; k < 3; k++) begin
         t3_5_ff[k] <= t3_4_ff[k];
         t4_5_ff[k] <= t4_4_ff[k];
         t5_5_ff[k] <= fmul(f4_ff[k], t4_4_ff[k]);
      end
      // quintic fade with clamp
      for (int k = 0; k < 8; k++) begin
         g6_ff[k] <= g5_ff[k];
      end
      for (int k = 0; k < 3; k++) begin
         if (fsum[k] < 23'sd0) begin
            fd6_ff[k] <= '0;
         end else if (fsum[k] > 23'sd65536) begin
            fd6_ff[k] <= 17'd65536;
         end else begin
            fd6_ff[k] <= fsum[k][16:0];
         end
      end
      // blend along x
      for (int k = 0; k < 4; k++) begin
         px7_ff[k] <= bmul(fd6_ff[0], g6_ff[2*k+1] - g6_ff[2*k]);
         ax7_ff[k] <= g6_ff[2*k];
      end
      fv7_ff <= fd6_ff[1];
      fw7_ff <= fd6_ff[2];
      for (int k = 0; k < 4; k++) begin
         bx8_ff[k] <= blend_sum(ax7_ff[k], px7_ff[k]);
      end
      fv8_ff <= fv7_ff;
      fw8_ff <= fw7_ff;
      // blend along y
      for (int k = 0; k < 2; k++) begin
         py9_ff[k] <= bmul(fv8_ff, bx8_ff[2*k+1] - bx8_ff[2*k]);
         ay9_ff[k] <= bx8_ff[2*k];
      end
      fw9_ff <= fw8_ff;
      for (int k = 0; k < 2; k++) begin
         by10_ff[k] <= blend_sum(ay9_ff[k], py9_ff[k]);
      end
      fw10_ff <= fw9_ff;
      // blend along z
      pz11_ff <= bmul(fw10_ff, by10_ff[1] - by10_ff[0]);
      az11_ff <= by10_ff[0];
      n12_ff  <= blend_sum(az11_ff, pz11_ff);
      // weight by amplitude, split in two partial products
      mlo13_ff <= n12_ff * $signed({1'b0, ampp_ff[12][20:0]});
      mhi13_ff <= n12_ff * $signed({1'b0, ampp_ff[12][40:21]});
   end

   // restoring divider, one quotient bit a cycle
   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         rem_ff <= 63'(mag) + 63'(weight_ff >> 1);
         dvs_ff <= 63'(weight_ff) << (DIV_STEPS - 1);
         quo_ff <= '0;
         neg_ff <= total_ff[63];
      end else if (cmd.div_step) begin
         if (rem_ff >= dvs_ff) begin
            rem_ff <= rem_ff - dvs_ff;
            quo_ff <= {quo_ff[17:0], 1'b1};
         end else begin
            quo_ff <= {quo_ff[17:0], 1'b0};
         end
         dvs_ff <= dvs_ff >> 1;
      end
   end

   logic signed [20:0] res;

   always_comb begin
      res = (neg_ff ? -$signed({2'b00, quo_ff}) : $signed({2'b00, quo_ff})) + 21'sd32768;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (res < -21'sd131072) begin
            out_ff <= 19'h40000;
         end else if (res > 21'sd196607) begin
            out_ff <= 19'h2FFFF;
         end else begin
            out_ff <= res[18:0];
         end
      end
   end

   assign status.pipe_busy = |vld_ff;
   assign noise_value      = out_ff;

endmodule

@@ design/fractal_perlin_noise_3d_top.sv @@
// fractal 3d perlin noise generator
//
// req channel: one transfer carries a point (x, y, z in signed q16.16).
// rsp channel: one transfer carries the noise value, signed q3.16, being the
// weighted octave sum divided by the weight total plus one half.
// csr port: write-only; seed, octave count, persistence and base frequency
// are written by index; the user must write them only while the block is
// idle, which the block itself does not enforce.
//
// timing: one point at a time. after the req transfer the set-up state forms
// the scaled coordinates, then the shared octave core takes one octave a
// cycle, its 13-stage pipeline drains, and the 19-step restoring divider
// normalises the sum, then the write state stores the result. the result
// sits in an output register, so the next point is accepted while rsp is
// stalled; a finished sample waits only if the register is still full.
// reset (synchronous) clears the controller, the output valid and restores
// the register defaults (one octave, persistence 0.5, freq 1.0).
module fractal_perlin_noise_3d_top
   import fpn3_pkg::*;
#(
   parameter int MAX_OCTAVES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // coord_x, coord_y, coord_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // noise_value, zero pad
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   // configuration registers
   logic [31:0] seed_ff;
   logic [3:0]  octaves_ff;
   logic [17:0] persist_ff;
   logic [23:0] basefrq_ff;

   cmd_type     cmd;
   status_type  status;
   logic [18:0] noise_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff    <= '0;
         octaves_ff <= 4'd1;
         persist_ff <= 18'd32768;
         basefrq_ff <= 24'd65536;
      end else if (csr_wr_en) begin
         case (csr_idx_type'(csr_index))
            CSR_SEED:    seed_ff    <= csr_wdata;
            CSR_OCTAVES: octaves_ff <= csr_wdata[3:0];
            CSR_PERSIST: persist_ff <= csr_wdata[17:0];
            CSR_BASEFRQ: basefrq_ff <= csr_wdata[23:0];
            default: begin
            end
         endcase
      end
   end

   // sequencing of set-up, octave issue, drain, divide and write-back
   fpn3_ctrl #(
      .MAX_OCTAVES(MAX_OCTAVES)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .octave_count (octaves_ff),
      .cmd          (cmd),
      .status       (status)
   );

   // octave core, accumulator and divider
   fpn3_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .in_data        (req_tdata),
      .noise_seed     (seed_ff),
      .persistence    (persist_ff),
      .base_frequency (basefrq_ff),
      .noise_value    (noise_value)
   );

   assign rsp_tdata = {5'd0, noise_value};

endmodule
